>>> rtl/core/esc_pkg.sv
package esc_pkg;

    // Calendar constants.
    localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR     = 12'd3600;
    localparam logic [11:0] SECS_PER_MIN      = 12'd60;
    localparam logic [16:0] DAYS_PER_WEEK     = 17'd7;
    localparam logic [16:0] EPOCH_WEEKDAY     = 17'd4;
    localparam logic [19:0] DAYS_PER_YEAR     = 20'd365;
    localparam logic [12:0] YEARS_PER_CENTURY = 13'd100;
    localparam logic [28:0] YEARS_PER_CYCLE   = 29'd400;
    localparam logic [8:0]  MARCH_YEAR_TAIL   = 9'd306;
    localparam logic [9:0]  GAUSS_OFFSET      = 10'd31;

    // Days from March 1 of year 1 BC to 1970-01-01, and the same plus two for
    // the 400-year cycle estimate.
    localparam logic [19:0] DAYS_TO_MARCH_1BC = 20'd719468;
    localparam logic [19:0] YEAR_EST_BIAS     = 20'd719470;

    // Reciprocal multipliers, rounded up. For every operand in range the
    // shifted product equals the exact floor of the quotient.
    localparam int unsigned DAY_SHIFT  = 35;
    localparam int unsigned HOUR_SHIFT = 30;
    localparam int unsigned MIN_SHIFT  = 20;
    localparam int unsigned WDAY_SHIFT = 20;
    localparam int unsigned YEAR_SHIFT = 48;
    localparam int unsigned CENT_SHIFT = 19;
    localparam int unsigned MON_SHIFT  = 20;

    // Seconds are first shifted right by 7, leaving a divide by 675.
    localparam logic [25:0] DAY_MUL =
        26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
    localparam logic [18:0] HOUR_MUL =
        19'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);
    localparam logic [14:0] MIN_MUL =
        15'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);
    localparam logic [17:0] WDAY_MUL =
        18'(((64'd1 << WDAY_SHIFT) + 64'd6) / 64'd7);
    localparam logic [30:0] YEAR_MUL =
        31'(((64'd1 << YEAR_SHIFT) + 64'd146096) / 64'd146097);
    localparam logic [12:0] CENT_MUL =
        13'(((64'd1 << CENT_SHIFT) + 64'd99) / 64'd100);
    // Gauss month: floor(x * 10 / 306) taken as floor(x * 5 / 153).
    localparam logic [15:0] MON_MUL =
        16'(((64'd5 << MON_SHIFT) + 64'd152) / 64'd153);

    // Day of the March-based year on which a Gauss month starts,
    // 367 * m / 12 - 30, for months 1 (March) through 12 (February).
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] start_day;
        case (mon)
            4'd1:    start_day = 9'd0;
            4'd2:    start_day = 9'd31;
            4'd3:    start_day = 9'd61;
            4'd4:    start_day = 9'd92;
            4'd5:    start_day = 9'd122;
            4'd6:    start_day = 9'd153;
            4'd7:    start_day = 9'd184;
            4'd8:    start_day = 9'd214;
            4'd9:    start_day = 9'd245;
            4'd10:   start_day = 9'd275;
            4'd11:   start_day = 9'd306;
            4'd12:   start_day = 9'd337;
            default: start_day = 9'd0;
        endcase
        return start_day;
    endfunction

endpackage

>>> rtl/core/epoch_seconds_to_calendar.sv
// Channel   Handshake           Payload
// -------   -----------------   ------------------------------------------------
// input     start / busy        epoch_seconds
// result    done (one cycle)    year_full, month_of_year, day_of_month,
//                               hour_of_day, minute_of_hour, second_of_minute,
//                               weekday
//
// One item enters per clock cycle. The work runs through ten register stages, each
// ending in one reciprocal multiply or the subtract and correction that follows one.
// The result of an item passes through stages 1 to 9 and the output registers, and is
// on the ports while done is high.
// busy stays low: the pipeline never holds, since the receiver takes every result.
// Reset clears only the valid bits; items in flight at reset are dropped.
module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic [11:0] year_full,
    output logic [3:0]  month_of_year,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute,
    output logic [2:0]  weekday
);

    localparam int unsigned NUM_STAGES = 10;

    // Valid bits travel alongside the data, one per stage.
    logic [NUM_STAGES-1:0] vld_reg, vld_next;

    // Stage 1: seconds and the day-count reciprocal product.
    logic [31:0] s1_secs_reg, s1_secs_next;
    logic [50:0] s1_pday_reg, s1_pday_next;
    // Stage 2: day count and second of day.
    logic [15:0] s2_days_reg, s2_days_next;
    logic [16:0] s2_rem_reg,  s2_rem_next;
    // Stage 3: products for hour, weekday, and the scaled year operand.
    logic [15:0] s3_days_reg, s3_days_next;
    logic [16:0] s3_rem_reg,  s3_rem_next;
    logic [35:0] s3_phr_reg,  s3_phr_next;
    logic [33:0] s3_pwd_reg,  s3_pwd_next;
    logic [28:0] s3_ydx_reg,  s3_ydx_next;
    // Stage 4: hour, second of hour, weekday, year product.
    logic [19:0] s4_mdays_reg, s4_mdays_next;
    logic [4:0]  s4_hour_reg,  s4_hour_next;
    logic [11:0] s4_rsec_reg,  s4_rsec_next;
    logic [2:0]  s4_wday_reg,  s4_wday_next;
    logic [59:0] s4_pyr_reg,   s4_pyr_next;
    // Stage 5: year estimate and minute product.
    logic [19:0] s5_mdays_reg, s5_mdays_next;
    logic [4:0]  s5_hour_reg,  s5_hour_next;
    logic [11:0] s5_rsec_reg,  s5_rsec_next;
    logic [2:0]  s5_wday_reg,  s5_wday_next;
    logic [11:0] s5_year_reg,  s5_year_next;
    logic [26:0] s5_pmin_reg,  s5_pmin_next;
    // Stage 6: minute, second, century product.
    logic [19:0] s6_mdays_reg, s6_mdays_next;
    logic [4:0]  s6_hour_reg,  s6_hour_next;
    logic [5:0]  s6_min_reg,   s6_min_next;
    logic [5:0]  s6_sec_reg,   s6_sec_next;
    logic [2:0]  s6_wday_reg,  s6_wday_next;
    logic [11:0] s6_year_reg,  s6_year_next;
    logic [24:0] s6_p100_reg,  s6_p100_next;
    // Stage 7: raw day of year and leap flag.
    logic [4:0]        s7_hour_reg, s7_hour_next;
    logic [5:0]        s7_min_reg,  s7_min_next;
    logic [5:0]        s7_sec_reg,  s7_sec_next;
    logic [2:0]        s7_wday_reg, s7_wday_next;
    logic [11:0]       s7_year_reg, s7_year_next;
    logic signed [11:0] s7_yday_reg, s7_yday_next;
    logic              s7_leap_reg, s7_leap_next;
    // Stage 8: corrected day of year.
    logic [4:0]  s8_hour_reg, s8_hour_next;
    logic [5:0]  s8_min_reg,  s8_min_next;
    logic [5:0]  s8_sec_reg,  s8_sec_next;
    logic [2:0]  s8_wday_reg, s8_wday_next;
    logic [11:0] s8_year_reg, s8_year_next;
    logic [8:0]  s8_yday_reg, s8_yday_next;
    // Stage 9: Gauss month product.
    logic [4:0]  s9_hour_reg, s9_hour_next;
    logic [5:0]  s9_min_reg,  s9_min_next;
    logic [5:0]  s9_sec_reg,  s9_sec_next;
    logic [2:0]  s9_wday_reg, s9_wday_next;
    logic [11:0] s9_year_reg, s9_year_next;
    logic [8:0]  s9_yday_reg, s9_yday_next;
    logic [25:0] s9_pmon_reg, s9_pmon_next;
    // Output registers.
    logic [11:0] out_year_reg, out_year_next;
    logic [3:0]  out_mon_reg,  out_mon_next;
    logic [4:0]  out_mday_reg, out_mday_next;
    logic [4:0]  out_hour_reg, out_hour_next;
    logic [5:0]  out_min_reg,  out_min_next;
    logic [5:0]  out_sec_reg,  out_sec_next;
    logic [2:0]  out_wday_reg, out_wday_next;

    // Intermediate values.
    logic [32:0] day_secs;
    logic [19:0] year_base;
    logic [16:0] hour_secs;
    logic [16:0] wday_x;
    logic [16:0] week_days;
    logic [19:0] year_op;
    logic [11:0] min_secs;
    logic [5:0]  cent_q;
    logic [3:0]  quad_cent_q;
    logic [19:0] year_days;
    logic [20:0] yday_wide;
    logic [12:0] cent_years;
    logic [11:0] yday_fixed;
    logic [9:0]  gauss_x;
    logic [3:0]  gauss_mon;
    logic [8:0]  mday_wide;

    always_comb
    begin
        // Nothing stalls, so the valid bits simply shift.
        vld_next = {vld_reg[NUM_STAGES-2:0], start};

        // Stage 1: floor(secs / 86400) = floor((secs >> 7) / 675).
        s1_secs_next = epoch_seconds;
        s1_pday_next = 51'(epoch_seconds[31:7]) * 51'(DAY_MUL);

        // Stage 2.
        s2_days_next = s1_pday_reg[50:35];
        day_secs     = 33'(s2_days_next) * 33'(SECS_PER_DAY);
        s2_rem_next  = 17'(s1_secs_reg - day_secs[31:0]);

        // Stage 3: 1970-01-01 was a Thursday.
        s3_days_next = s2_days_reg;
        s3_rem_next  = s2_rem_reg;
        s3_phr_next  = 36'(s2_rem_reg) * 36'(HOUR_MUL);
        wday_x       = 17'(s2_days_reg) + EPOCH_WEEKDAY;
        s3_pwd_next  = 34'(wday_x) * 34'(WDAY_MUL);
        year_op      = 20'(s2_days_reg) + YEAR_EST_BIAS;
        s3_ydx_next  = 29'(year_op) * YEARS_PER_CYCLE;

        // Stage 4.
        s4_hour_next  = s3_phr_reg[34:30];
        hour_secs     = 17'(s4_hour_next) * 17'(SECS_PER_HOUR);
        s4_rsec_next  = 12'(s3_rem_reg - hour_secs);
        week_days     = 17'(s3_pwd_reg[33:20]) * DAYS_PER_WEEK;
        s4_wday_next  = 3'((17'(s3_days_reg) + EPOCH_WEEKDAY) - week_days);
        s4_pyr_next   = 60'(s3_ydx_reg) * 60'(YEAR_MUL);
        s4_mdays_next = 20'(s3_days_reg) + DAYS_TO_MARCH_1BC;

        // Stage 5: March-based year estimate from the 400-year cycle.
        s5_mdays_next = s4_mdays_reg;
        s5_hour_next  = s4_hour_reg;
        s5_rsec_next  = s4_rsec_reg;
        s5_wday_next  = s4_wday_reg;
        s5_year_next  = s4_pyr_reg[59:48];
        s5_pmin_next  = 27'(s4_rsec_reg) * 27'(MIN_MUL);

        // Stage 6.
        s6_mdays_next = s5_mdays_reg;
        s6_hour_next  = s5_hour_reg;
        s6_wday_next  = s5_wday_reg;
        s6_year_next  = s5_year_reg;
        s6_min_next   = s5_pmin_reg[25:20];
        min_secs      = 12'(s6_min_next) * SECS_PER_MIN;
        s6_sec_next   = 6'(s5_rsec_reg - min_secs);
        s6_p100_next  = 25'(s5_year_reg) * 25'(CENT_MUL);

        // Stage 7: day of year against the estimated year, which may be
        // one too high and leave the day of year negative.
        s7_hour_next = s6_hour_reg;
        s7_min_next  = s6_min_reg;
        s7_sec_next  = s6_sec_reg;
        s7_wday_next = s6_wday_reg;
        s7_year_next = s6_year_reg;
        cent_q       = s6_p100_reg[24:19];
        quad_cent_q  = cent_q[5:2];
        year_base    = 20'(s6_year_reg) * DAYS_PER_YEAR;
        year_days    = year_base + 20'(s6_year_reg[11:2]) - 20'(cent_q)
                       + 20'(quad_cent_q);
        yday_wide    = 21'(s6_mdays_reg) - 21'(year_days);
        s7_yday_next = 12'(yday_wide);
        cent_years   = 13'(cent_q) * YEARS_PER_CENTURY;
        s7_leap_next = (s6_year_reg[1:0] == 2'b00)
                       && ((13'(s6_year_reg) != cent_years) || (cent_q[1:0] == 2'b00));

        // Stage 8: step back one year when the day of year went negative.
        s8_hour_next = s7_hour_reg;
        s8_min_next  = s7_min_reg;
        s8_sec_next  = s7_sec_reg;
        s8_wday_next = s7_wday_reg;
        yday_fixed   = s7_yday_reg + 12'(DAYS_PER_YEAR) + 12'(s7_leap_reg);
        if (s7_yday_reg[11])
        begin
            s8_yday_next = yday_fixed[8:0];
            s8_year_next = s7_year_reg - 12'd1;
        end
        else
        begin
            s8_yday_next = s7_yday_reg[8:0];
            s8_year_next = s7_year_reg;
        end

        // Stage 9: Gauss month, counted from March.
        s9_hour_next = s8_hour_reg;
        s9_min_next  = s8_min_reg;
        s9_sec_next  = s8_sec_reg;
        s9_wday_next = s8_wday_reg;
        s9_year_next = s8_year_reg;
        s9_yday_next = s8_yday_reg;
        gauss_x      = 10'(s8_yday_reg) + GAUSS_OFFSET;
        s9_pmon_next = 26'(gauss_x) * 26'(MON_MUL);

        // Output stage: day of month, then January and February move
        // into the following calendar year.
        out_hour_next = s9_hour_reg;
        out_min_next  = s9_min_reg;
        out_sec_next  = s9_sec_reg;
        out_wday_next = s9_wday_reg;
        gauss_mon     = s9_pmon_reg[23:20];
        mday_wide     = s9_yday_reg - month_start(gauss_mon) + 9'd1;
        out_mday_next = mday_wide[4:0];
        if (s9_yday_reg >= MARCH_YEAR_TAIL)
        begin
            out_year_next = s9_year_reg + 12'd1;
            out_mon_next  = gauss_mon - 4'd10;
        end
        else
        begin
            out_year_next = s9_year_reg;
            out_mon_next  = gauss_mon + 4'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_secs_reg  <= s1_secs_next;
        s1_pday_reg  <= s1_pday_next;

        s2_days_reg  <= s2_days_next;
        s2_rem_reg   <= s2_rem_next;

        s3_days_reg  <= s3_days_next;
        s3_rem_reg   <= s3_rem_next;
        s3_phr_reg   <= s3_phr_next;
        s3_pwd_reg   <= s3_pwd_next;
        s3_ydx_reg   <= s3_ydx_next;

        s4_mdays_reg <= s4_mdays_next;
        s4_hour_reg  <= s4_hour_next;
        s4_rsec_reg  <= s4_rsec_next;
        s4_wday_reg  <= s4_wday_next;
        s4_pyr_reg   <= s4_pyr_next;

        s5_mdays_reg <= s5_mdays_next;
        s5_hour_reg  <= s5_hour_next;
        s5_rsec_reg  <= s5_rsec_next;
        s5_wday_reg  <= s5_wday_next;
        s5_year_reg  <= s5_year_next;
        s5_pmin_reg  <= s5_pmin_next;

        s6_mdays_reg <= s6_mdays_next;
        s6_hour_reg  <= s6_hour_next;
        s6_min_reg   <= s6_min_next;
        s6_sec_reg   <= s6_sec_next;
        s6_wday_reg  <= s6_wday_next;
        s6_year_reg  <= s6_year_next;
        s6_p100_reg  <= s6_p100_next;

        s7_hour_reg  <= s7_hour_next;
        s7_min_reg   <= s7_min_next;
        s7_sec_reg   <= s7_sec_next;
        s7_wday_reg  <= s7_wday_next;
        s7_year_reg  <= s7_year_next;
        s7_yday_reg  <= s7_yday_next;
        s7_leap_reg  <= s7_leap_next;

        s8_hour_reg  <= s8_hour_next;
        s8_min_reg   <= s8_min_next;
        s8_sec_reg   <= s8_sec_next;
        s8_wday_reg  <= s8_wday_next;
        s8_year_reg  <= s8_year_next;
        s8_yday_reg  <= s8_yday_next;

        s9_hour_reg  <= s9_hour_next;
        s9_min_reg   <= s9_min_next;
        s9_sec_reg   <= s9_sec_next;
        s9_wday_reg  <= s9_wday_next;
        s9_year_reg  <= s9_year_next;
        s9_yday_reg  <= s9_yday_next;
        s9_pmon_reg  <= s9_pmon_next;

        out_year_reg <= out_year_next;
        out_mon_reg  <= out_mon_next;
        out_mday_reg <= out_mday_next;
        out_hour_reg <= out_hour_next;
        out_min_reg  <= out_min_next;
        out_sec_reg  <= out_sec_next;
        out_wday_reg <= out_wday_next;
    end

    assign busy             = 1'b0;
    assign done             = vld_reg[NUM_STAGES-1];
    assign year_full        = out_year_reg;
    assign month_of_year    = out_mon_reg;
    assign day_of_month     = out_mday_reg;
    assign hour_of_day      = out_hour_reg;
    assign minute_of_hour   = out_min_reg;
    assign second_of_minute = out_sec_reg;
    assign weekday          = out_wday_reg;

endmodule

>>> test/tb_epoch_seconds_to_calendar.sv
// Testbench for epoch_seconds_to_calendar.
//
// A queue of pending timestamps is filled at time zero. A clocked driver
// presents them one item at a time on start/epoch_seconds and honors busy,
// leaving the idle gap set for each item in front of it. A clocked monitor sees every
// accepted item, works out the calendar fields it must produce, and checks
// each done strobe against the oldest outstanding expectation. The block has
// no configuration and keeps nothing from one item to the next, so the
// prediction is a pure function of the timestamp.
module tb_epoch_seconds_to_calendar;

    // The tail wait covers the result latency of the block.
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 40;
    localparam longint SECS_PER_DAY = 86400;
    localparam longint SECS_MAX = 64'hFFFF_FFFF;

    // One timestamp waiting to be driven. idle_cycles is the gap the driver
    // leaves in front of it; wait_for_results makes the driver hold it back
    // until every result issued so far has come out.
    typedef struct {
        logic [31:0] secs;
        int          idle_cycles;
        bit          wait_for_results;
    } stamp_item_t;

    // Calendar fields for one timestamp, at the widths of the result ports.
    typedef struct {
        logic [31:0] secs;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } calendar_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] epoch_seconds = '0;
    logic        busy;
    logic        done;
    logic [11:0] year_full;
    logic [3:0]  month_of_year;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [2:0]  weekday;

    stamp_item_t pending_stamps[$];
    calendar_t   calendar_expected[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          idle_left = 0;
    bit          gap_served = 1'b0;

    epoch_seconds_to_calendar uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .year_full        (year_full),
        .month_of_year    (month_of_year),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .weekday          (weekday)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Converts a timestamp to calendar fields. The day count is rebased to
    // March 1 of year 1 BC so that the leap day falls at the end of the
    // March-based year; the year comes from the 400-year cycle length and is
    // stepped back when that estimate lands past the start of the day.
    function automatic calendar_t calendar_from_seconds(input logic [31:0] secs);
        calendar_t res;
        longint    days;
        longint    rem;
        longint    mdays;
        longint    yr;
        longint    yday;
        longint    mon;
        longint    mday;
        bit        leap;
        days  = longint'(secs) / SECS_PER_DAY;
        rem   = longint'(secs) % SECS_PER_DAY;
        mdays = days + 719468;
        yr    = (mdays + 2) * 400 / 146097;
        yday  = mdays - (365 * yr + yr / 4 - yr / 100 + yr / 400);
        if (yday < 0)
        begin
            // Overshoot: the length of that March-based year depends on
            // whether its closing February (in calendar year yr) is a leap one.
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            yday = yday + 365 + (leap ? 1 : 0);
            yr   = yr - 1;
        end
        mon  = (yday + 31) * 10 / 306;
        mday = yday - (367 * mon / 12 - 30) + 1;
        // January and February close the March-based year, so they belong to
        // the next calendar year.
        if (yday >= 306)
        begin
            yr  = yr + 1;
            mon = mon - 10;
        end
        else
        begin
            mon = mon + 2;
        end
        res.secs   = secs;
        res.year   = 12'(yr);
        res.month  = 4'(mon);
        res.mday   = 5'(mday);
        res.hour   = 5'(rem / 3600);
        res.minute = 6'((rem % 3600) / 60);
        res.second = 6'(rem % 60);
        res.wday   = 3'((4 + days) % 7);
        return res;
    endfunction

    // Days from 1970-01-01 to January 1 of the given year.
    function automatic longint days_to_new_year(input longint yr);
        longint y;
        longint base;
        y    = yr - 1;
        base = 365 * 1969 + 1969 / 4 - 1969 / 100 + 1969 / 400;
        return 365 * y + y / 4 - y / 100 + y / 400 - base;
    endfunction

    function automatic logic [31:0] clamp_to_epoch(input longint secs);
        if (secs < 0)
            return '0;
        if (secs > SECS_MAX)
            return 32'hFFFF_FFFF;
        return 32'(secs);
    endfunction

    task automatic add_stamp(input logic [31:0] secs, input int idle_cycles,
                             input bit wait_for_results);
        stamp_item_t it;
        it.secs             = secs;
        it.idle_cycles      = idle_cycles;
        it.wait_for_results = wait_for_results;
        pending_stamps.push_back(it);
    endtask

    // Every mismatch goes through here. Printing is capped so a badly broken
    // block cannot flood the log, but every mismatch is counted.
    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input longint got,
                               input longint want, input logic [31:0] secs);
        if (got != want)
            report_mismatch($sformatf("%s for %0d: got %0d, expected %0d",
                                      field, secs, got, want));
    endtask

    // Driver. A held item (start high while busy) is left untouched. Otherwise
    // the next item is presented after its idle gap, and an item marked to wait
    // for results is held back until nothing is outstanding. start is assigned
    // once per edge so it stays high across back-to-back items.
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        logic present;
        if (!rst_n)
        begin
            start         <= 1'b0;
            epoch_seconds <= '0;
            idle_left     <= 0;
        end
        else if (!(start && busy))
        begin
            present = 1'b0;
            if (idle_left != 0)
            begin
                idle_left <= idle_left - 1;
            end
            else if (pending_stamps.size() != 0)
            begin
                if (!gap_served && pending_stamps[0].idle_cycles != 0)
                begin
                    // This cycle is the first idle one of the gap.
                    idle_left  <= pending_stamps[0].idle_cycles - 1;
                    gap_served = 1'b1;
                end
                else if (!pending_stamps[0].wait_for_results ||
                         (!start && calendar_expected.size() == 0))
                begin
                    present       = 1'b1;
                    epoch_seconds <= pending_stamps[0].secs;
                    void'(pending_stamps.pop_front());
                    gap_served = 1'b0;
                end
            end
            start <= present;
        end
    end

    // Monitor. Expectations are queued at the accepting edge, and each done
    // strobe is matched against the oldest one. Both happen in this block so
    // the order within an edge is fixed.
    always @(posedge clk)
    begin : result_monitor
        calendar_t want;
        if (rst_n)
        begin
            if (start && !busy)
                calendar_expected.push_back(calendar_from_seconds(epoch_seconds));
            if (done)
            begin
                if (calendar_expected.size() == 0)
                begin
                    report_mismatch("result strobe with no item outstanding");
                end
                else
                begin
                    want = calendar_expected.pop_front();
                    check_field("year", year_full, want.year, want.secs);
                    check_field("month", month_of_year, want.month, want.secs);
                    check_field("day", day_of_month, want.mday, want.secs);
                    check_field("hour", hour_of_day, want.hour, want.secs);
                    check_field("minute", minute_of_hour, want.minute, want.secs);
                    check_field("second", second_of_minute, want.second, want.secs);
                    check_field("weekday", weekday, want.wday, want.secs);
                end
            end
        end
    end

    // Watchdog: a lost result or a stuck handshake ends up here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        longint yr;
        longint day_base;
        longint offset;
        bit     no_idle;
        bit     march;
        int     kind;
        int     gap;
        logic [31:0] secs;

        // Directed items: field extremes, time-of-day wraps, the leap-day and
        // century cases, the March 1 boundary where the year estimate
        // overshoots, and January/February folding into the next year.
        add_stamp(32'd0, 0, 1'b0);              // epoch start, a Thursday
        add_stamp(32'hFFFF_FFFF, 0, 1'b0);      // last representable second
        add_stamp(32'd59, 1, 1'b0);
        add_stamp(32'd60, 0, 1'b0);
        add_stamp(32'd3599, 0, 1'b0);
        add_stamp(32'd86399, 2, 1'b0);          // 23:59:59 on the first day
        add_stamp(32'd86400, 0, 1'b0);
        add_stamp(32'd36633599, 0, 1'b0);       // last second of Feb 1971
        add_stamp(32'd36633600, 0, 1'b0);       // March 1 1971
        add_stamp(32'd68169600, 3, 1'b0);       // Feb 29 1972
        add_stamp(32'd68256000, 0, 1'b0);       // March 1 1972
        add_stamp(32'd946684799, 0, 1'b0);      // last second of 1999
        add_stamp(32'd951782400, 0, 1'b0);      // Feb 29 2000, a 400-year leap
        add_stamp(32'd951868800, 10, 1'b0);     // March 1 2000
        add_stamp(32'd978307199, 0, 1'b0);      // Dec 31 2000, day 366
        add_stamp(32'd978307200, 0, 1'b0);
        add_stamp(32'h7FFF_FFFF, 0, 1'b0);
        add_stamp(32'h8000_0000, 0, 1'b0);
        add_stamp(32'hAAAA_AAAA, 0, 1'b0);
        add_stamp(32'h5555_5555, 0, 1'b0);
        add_stamp(32'd4107542399, 0, 1'b0);     // Feb 28 2100, not a leap year
        add_stamp(32'd4107542400, 0, 1'b0);     // March 1 2100
        add_stamp(32'd4291833600, 0, 1'b0);     // Jan 2 2106

        // Random part in bursts of 50: some bursts run without idling, the
        // rest draw a gap per item. Timestamps cluster on the calendar's
        // awkward spots (new year, March 1, midnight) as well as uniform draws.
        for (int blk = 0; blk < 16; blk++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 50; k++)
            begin
                kind = $urandom_range(0, 3);
                case (kind)
                    0:
                    begin
                        secs = $urandom;
                    end
                    1, 2:
                    begin
                        yr       = $urandom_range(1970, 2106);
                        day_base = days_to_new_year(yr);
                        march    = (kind == 1);
                        if (march)
                        begin
                            // Day 59 of the year, or 60 in a leap year.
                            day_base = day_base + 59 +
                                ((yr % 4 == 0 && (yr % 100 != 0 || yr % 400 == 0)) ? 1 : 0);
                        end
                        offset = longint'($urandom_range(0, 4 * 86400)) - 2 * SECS_PER_DAY;
                        secs   = clamp_to_epoch(day_base * SECS_PER_DAY + offset);
                    end
                    default:
                    begin
                        day_base = $urandom_range(0, 49710);
                        offset   = ($urandom_range(0, 1) == 1) ? 86399 : 0;
                        secs     = clamp_to_epoch(day_base * SECS_PER_DAY + offset);
                    end
                endcase
                gap = no_idle ? 0 : $urandom_range(0, 10);
                // Drain the pipeline before the random part and twice within it.
                add_stamp(secs, gap, (k == 0) && (blk == 0 || blk == 7 || blk == 12));
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_stamps.size() != 0 || start || calendar_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        // Any expectation still queued here is a result that never came out.
        if (calendar_expected.size() != 0)
            report_mismatch($sformatf("%0d results never came out",
                                      calendar_expected.size()));

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
